FILE: rtl/desu_pkg.sv
// ----------------------------------------------------------------------------
// desu_pkg - shared types, codes and helpers for the excitation sign unit
// Operation codes, sign codes, widths and the masked-parity helpers.
// ----------------------------------------------------------------------------
package desu_pkg;

    localparam int W_WORD          = 64;
    localparam int W_IDX           = 6;
    localparam int W_CNT           = 7;
    localparam int W_POS           = 7;
    localparam int W_OP            = 4;
    localparam int W_SIGN          = 2;
    localparam int MAX_ORBITALS_DEF = 64;

    localparam logic [W_CNT-1:0] CNT_RESET = 7'd64;

    // operation codes
    localparam logic [W_OP-1:0] OP_LOAD  = 4'd0;
    localparam logic [W_OP-1:0] OP_CRE   = 4'd1;
    localparam logic [W_OP-1:0] OP_ANN   = 4'd2;
    localparam logic [W_OP-1:0] OP_SGL   = 4'd3;
    localparam logic [W_OP-1:0] OP_DAA   = 4'd4;
    localparam logic [W_OP-1:0] OP_DAB   = 4'd5;
    localparam logic [W_OP-1:0] OP_DBB   = 4'd6;
    localparam logic [W_OP-1:0] OP_FLIP  = 4'd7;
    localparam logic [W_OP-1:0] OP_ZERO  = 4'd8;

    // sign codes, two's complement
    localparam logic signed [W_SIGN-1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [W_SIGN-1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [W_SIGN-1:0] SIGN_NEG  = 2'sb11;
    localparam logic signed [W_SIGN-1:0] SIGN_BAD  = 2'sb10;

    typedef logic [W_WORD-1:0] t_word;
    typedef logic [W_POS-1:0]  t_pos;

    // bits lo .. hi-1 set; empty when hi <= lo
    function automatic t_word f_range_mask(input logic [7:0] lo, input logic [7:0] hi);
        t_word m;
        for (int k = 0; k < W_WORD; k++) begin
            m[k] = (8'(k) >= lo) && (8'(k) < hi);
        end
        return m;
    endfunction

    // parity of set bits strictly between combined positions x and y;
    // alpha holds positions 0 .. n-1, beta holds n .. 2n-1
    function automatic logic f_between(input t_pos x, input t_pos y,
                                       input logic [W_CNT-1:0] n,
                                       input t_word aw, input t_word bw);
        t_pos       lo;
        t_pos       hi;
        logic [7:0] alo;
        logic [7:0] ahi;
        logic [7:0] blo;
        logic [7:0] bhi;
        lo  = (x < y) ? x : y;
        hi  = (x < y) ? y : x;
        alo = {1'b0, lo} + 8'd1;
        ahi = (hi < n) ? {1'b0, hi} : {1'b0, n};
        blo = (alo > {1'b0, n}) ? alo - {1'b0, n} : 8'd0;
        bhi = (hi > n) ? {1'b0, hi} - {1'b0, n} : 8'd0;
        return (^(aw & f_range_mask(alo, ahi))) ^ (^(bw & f_range_mask(blo, bhi)));
    endfunction

endpackage

FILE: rtl/determinant_excitation_sign_unit.sv
// ----------------------------------------------------------------------------
// determinant_excitation_sign_unit - fermionic excitation phase unit
// Holds one alpha/beta occupation determinant, applies one operator per beat.
// ----------------------------------------------------------------------------
// Takes one operation beat per clock and returns one result beat for each,
// in order. An accepted beat is held in the input register; the single pass
// of decode, bit update and masked-parity logic from that register writes
// the determinant words and the result register together once the result
// register is free; the outputs come straight from the result register, and
// the next beat sees the updated determinant.
// Sustained rate is one beat per cycle, limited only by
// the result register draining: o_in_stall rises only while a result waits
// under i_out_stall and the input register is full. The sign is +1/-1 as
// 2'sb01/2'sb11, and 0 for impossible create/annihilate, load, spin flip,
// zero spin, unused codes and out-of-range indices (those also raise o_error
// and leave the determinant untouched). Doubles take their parities in the
// combined order, alpha orbitals first, beta orbitals after the n in use.
// The orbital count register resets to 64, saturates at P_MAX_ORBITALS and
// should be written only while the unit is idle.
module determinant_excitation_sign_unit #(
    parameter int P_MAX_ORBITALS = desu_pkg::MAX_ORBITALS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [desu_pkg::W_CNT-1:0]          i_cfg_wdata,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [desu_pkg::W_OP-1:0]           i_op,
    input  logic                                i_spin,
    input  logic [desu_pkg::W_IDX-1:0]          i_idx_i,
    input  logic [desu_pkg::W_IDX-1:0]          i_idx_j,
    input  logic [desu_pkg::W_IDX-1:0]          i_idx_a,
    input  logic [desu_pkg::W_IDX-1:0]          i_idx_b,
    input  logic [desu_pkg::W_WORD-1:0]         i_load_alpha,
    input  logic [desu_pkg::W_WORD-1:0]         i_load_beta,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [desu_pkg::W_SIGN-1:0]  o_sign,
    output logic [desu_pkg::W_WORD-1:0]         o_alpha_word,
    output logic [desu_pkg::W_WORD-1:0]         o_beta_word,
    output logic                                o_error
);
    import desu_pkg::*;

    localparam logic [W_CNT-1:0] MAX_N = W_CNT'(P_MAX_ORBITALS);

    // configuration and determinant
    logic [W_CNT-1:0] r_cnt;
    t_word            r_alpha_occ;
    t_word            r_beta_occ;

    // input register
    logic             r_in_valid;
    logic [W_OP-1:0]  r_op;
    logic             r_spin;
    logic [W_IDX-1:0] r_idx_i;
    logic [W_IDX-1:0] r_idx_j;
    logic [W_IDX-1:0] r_idx_a;
    logic [W_IDX-1:0] r_idx_b;
    t_word            r_load_alpha;
    t_word            r_load_beta;

    // result register
    logic                     r_out_valid;
    logic signed [W_SIGN-1:0] r_sign;
    t_word                    r_out_alpha;
    t_word                    r_out_beta;
    logic                     r_error;

    // single-pass results
    logic                     n_error;
    logic signed [W_SIGN-1:0] n_sign;
    t_word                    n_alpha;
    t_word                    n_beta;

    // handshake
    logic out_free;
    logic advance;
    logic take_in;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take_in    = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------- compute
    logic [W_CNT-1:0] n_eff;
    t_word            lowm;
    t_word            mi, mj, ma, mb;
    t_word            w_sel, w_upd;
    logic             bit_set;
    logic             oor_i, oor_j, oor_a, oor_b;
    logic [W_CNT-1:0] off;
    logic             ia_beta, jb_beta;
    t_word            a_clr, a_set, b_clr, b_set;
    t_pos             pi, pj, pa, pb;
    t_word            d_alpha, d_beta;
    logic             p_ij, p_ab, p_ib, p_ja, p_ia, p_jb;
    logic             below, above, flip, neg;
    t_word            s_alpha, s_beta;
    logic             s_par;

    always_comb begin
        n_eff  = (r_cnt > MAX_N) ? MAX_N : r_cnt;
        lowm   = f_range_mask(8'd0, {1'b0, n_eff});
        mi     = t_word'(1) << r_idx_i;
        mj     = t_word'(1) << r_idx_j;
        ma     = t_word'(1) << r_idx_a;
        mb     = t_word'(1) << r_idx_b;
        oor_i  = {1'b0, r_idx_i} >= n_eff;
        oor_j  = {1'b0, r_idx_j} >= n_eff;
        oor_a  = {1'b0, r_idx_a} >= n_eff;
        oor_b  = {1'b0, r_idx_b} >= n_eff;
        off    = r_spin ? n_eff : '0;

        // create / annihilate / single on the chosen spin
        w_sel   = r_spin ? r_beta_occ : r_alpha_occ;
        bit_set = w_sel[r_idx_i];
        w_upd   = (w_sel & ~mi) | ma;
        s_alpha = r_spin ? r_alpha_occ : w_upd;
        s_beta  = r_spin ? w_upd : r_beta_occ;
        s_par   = f_between({1'b0, r_idx_i} + off, {1'b0, r_idx_a} + off,
                            n_eff, s_alpha, s_beta);

        // doubles: holes cleared first, then particles set
        ia_beta = (r_op == OP_DBB);
        jb_beta = (r_op != OP_DAA);
        a_clr   = (ia_beta ? '0 : mi) | (jb_beta ? '0 : mj);
        a_set   = (ia_beta ? '0 : ma) | (jb_beta ? '0 : mb);
        b_clr   = (ia_beta ? mi : '0) | (jb_beta ? mj : '0);
        b_set   = (ia_beta ? ma : '0) | (jb_beta ? mb : '0);
        d_alpha = (r_alpha_occ & ~a_clr) | a_set;
        d_beta  = (r_beta_occ & ~b_clr) | b_set;
        pi      = {1'b0, r_idx_i} + (ia_beta ? n_eff : '0);
        pa      = {1'b0, r_idx_a} + (ia_beta ? n_eff : '0);
        pj      = {1'b0, r_idx_j} + (jb_beta ? n_eff : '0);
        pb      = {1'b0, r_idx_b} + (jb_beta ? n_eff : '0);
        p_ij    = f_between(pi, pj, n_eff, d_alpha, d_beta);
        p_ab    = f_between(pa, pb, n_eff, d_alpha, d_beta);
        p_ib    = f_between(pi, pb, n_eff, d_alpha, d_beta);
        p_ja    = f_between(pj, pa, n_eff, d_alpha, d_beta);
        p_ia    = f_between(pi, pa, n_eff, d_alpha, d_beta);
        p_jb    = f_between(pj, pb, n_eff, d_alpha, d_beta);
        below   = (pi < pa) && (pj < pa) && (pi < pb) && (pj < pb);
        above   = !((pi < pa) || (pj < pa) || (pi < pb) || (pj < pb));
        flip    = (pi < pj) != (pa < pb);
        if (below || above) begin
            neg = flip ^ p_ij ^ p_ab;
        end else if (flip) begin
            neg = 1'b1 ^ p_ib ^ p_ja;
        end else begin
            neg = p_ia ^ p_jb;
        end

        n_error = 1'b0;
        n_sign  = SIGN_ZERO;
        n_alpha = r_alpha_occ;
        n_beta  = r_beta_occ;

        case (r_op)
            OP_LOAD: begin
                n_alpha = r_load_alpha & lowm;
                n_beta  = r_load_beta & lowm;
            end
            OP_CRE, OP_ANN: begin
                if (oor_i) begin
                    n_error = 1'b1;
                end else if ((r_op == OP_CRE) != bit_set) begin
                    // bits below i are untouched by the flip
                    n_sign = (^(w_sel & (mi - t_word'(1)))) ? SIGN_NEG : SIGN_POS;
                    if (r_spin) begin
                        n_beta = w_sel ^ mi;
                    end else begin
                        n_alpha = w_sel ^ mi;
                    end
                end
            end
            OP_SGL: begin
                if (oor_i || oor_a) begin
                    n_error = 1'b1;
                end else begin
                    n_alpha = s_alpha;
                    n_beta  = s_beta;
                    n_sign  = s_par ? SIGN_NEG : SIGN_POS;
                end
            end
            OP_DAA, OP_DAB, OP_DBB: begin
                if (oor_i || oor_j || oor_a || oor_b) begin
                    n_error = 1'b1;
                end else begin
                    n_alpha = d_alpha;
                    n_beta  = d_beta;
                    n_sign  = neg ? SIGN_NEG : SIGN_POS;
                end
            end
            OP_FLIP: begin
                n_alpha = (r_alpha_occ & ~lowm) | (r_beta_occ & lowm);
                n_beta  = (r_beta_occ & ~lowm) | (r_alpha_occ & lowm);
            end
            OP_ZERO: begin
                if (r_spin) begin
                    n_beta = r_beta_occ & ~lowm;
                end else begin
                    n_alpha = r_alpha_occ & ~lowm;
                end
            end
            default: begin
                n_error = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= CNT_RESET;
            r_alpha_occ <= '0;
            r_beta_occ  <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (advance) begin
                r_alpha_occ <= n_alpha;
                r_beta_occ  <= n_beta;
            end
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_op         <= i_op;
            r_spin       <= i_spin;
            r_idx_i      <= i_idx_i;
            r_idx_j      <= i_idx_j;
            r_idx_a      <= i_idx_a;
            r_idx_b      <= i_idx_b;
            r_load_alpha <= i_load_alpha;
            r_load_beta  <= i_load_beta;
        end
        if (advance) begin
            r_sign      <= n_sign;
            r_out_alpha <= n_alpha;
            r_out_beta  <= n_beta;
            r_error     <= n_error;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sign       = r_sign;
    assign o_alpha_word = r_out_alpha;
    assign o_beta_word  = r_out_beta;
    assign o_error      = r_error;

endmodule

FILE: rtl/desu_checker.sv
// ----------------------------------------------------------------------------
// desu_checker - port-level checks for the excitation sign unit
// Watches the top-level ports; attached by the bind below.
// ----------------------------------------------------------------------------
module desu_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [desu_pkg::W_SIGN-1:0]  o_sign,
    input  logic [desu_pkg::W_WORD-1:0]         o_alpha_word,
    input  logic [desu_pkg::W_WORD-1:0]         o_beta_word,
    input  logic                                o_error
);
    import desu_pkg::*;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_alpha_word)
            && $stable(o_beta_word) && $stable(o_sign) && $stable(o_error))
        else $error("result beat changed while stalled");

    // input side backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without downstream back-pressure");

    // range errors never carry a phase
    a_err_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_sign == SIGN_ZERO)
        else $error("error beat with nonzero sign");

    a_sign_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sign != SIGN_BAD)
        else $error("illegal sign code");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind determinant_excitation_sign_unit desu_checker u_desu_checker (.*);

FILE: bench/desu_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desu_tb_pkg - determinant phase predictor and result board
// Tracks the alpha/beta occupation words and the orbital count on the bench
// side, works out the sign and words for each accepted operator beat, and
// checks the result beats against them in order.
// ----------------------------------------------------------------------------
package desu_tb_pkg;

    import desu_pkg::*;

    typedef struct packed {
        logic [W_SIGN-1:0] sign;
        t_word             alpha;
        t_word             beta;
        logic              err;
    } t_phase_beat;

    class t_excitation_phase_board;

        t_word             alpha_occ;
        t_word             beta_occ;
        logic [W_CNT-1:0]  orb_count;
        t_phase_beat       expected_beats[$];
        int unsigned       beats_in;
        int unsigned       beats_out;
        int unsigned       mismatches;

        function new();
            alpha_occ  = '0;
            beta_occ   = '0;
            orb_count  = CNT_RESET;
            beats_in   = 0;
            beats_out  = 0;
            mismatches = 0;
        endfunction

        function void set_count(logic [W_CNT-1:0] c);
            orb_count = c;
        endfunction

        function int orbitals_in_use();
            return (orb_count > MAX_ORBITALS_DEF) ? MAX_ORBITALS_DEF : int'(orb_count);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // bits lo .. hi-1
        function t_word span(int lo, int hi);
            t_word m;
            for (int k = 0; k < W_WORD; k++) begin
                m[k] = (k >= lo) && (k < hi);
            end
            return m;
        endfunction

        // parity strictly between two combined positions (beta starts at n)
        function logic gap_parity(int x, int y);
            int n;
            int lo;
            int hi;
            int blo;
            int bhi;
            n   = orbitals_in_use();
            lo  = (x < y) ? x : y;
            hi  = (x < y) ? y : x;
            blo = (lo + 1 > n) ? lo + 1 - n : 0;
            bhi = (hi > n) ? hi - n : 0;
            return (^(alpha_occ & span(lo + 1, (hi < n) ? hi : n))) ^
                   (^(beta_occ & span(blo, bhi)));
        endfunction

        function void put_bit(int pos, logic v);
            int n;
            int p;
            n = orbitals_in_use();
            p = (pos >= n) ? (pos - n) & 63 : pos & 63;
            if (pos >= n) beta_occ[p] = v;
            else alpha_occ[p] = v;
        endfunction

        // predict the result of one accepted operator beat
        function void apply_operator(logic [W_OP-1:0] op, logic spin,
                                     logic [W_IDX-1:0] ii, logic [W_IDX-1:0] jj,
                                     logic [W_IDX-1:0] aa, logic [W_IDX-1:0] bb,
                                     t_word la, t_word lb);
            int          n;
            int          off;
            int          pi;
            int          pj;
            int          pa;
            int          pb;
            int          oi;
            int          oj;
            t_word       lowm;
            t_word       onehot;
            t_word       ta;
            t_word       tb;
            logic        occupied;
            logic        odd;
            logic        hb;
            logic        ha;
            logic        crossed;
            t_phase_beat beat;
            n             = orbitals_in_use();
            lowm          = span(0, n);
            off           = spin ? n : 0;
            beat.sign     = SIGN_ZERO;
            beat.err      = 1'b0;
            case (op)
                OP_LOAD: begin
                    alpha_occ = la & lowm;
                    beta_occ  = lb & lowm;
                end
                OP_CRE, OP_ANN: begin
                    if (int'(ii) >= n) begin
                        beat.err = 1'b1;
                    end else begin
                        onehot   = t_word'(1) << ii;
                        occupied = spin ? |(beta_occ & onehot) : |(alpha_occ & onehot);
                        if ((op == OP_CRE) != occupied) begin
                            if (spin) beta_occ ^= onehot;
                            else alpha_occ ^= onehot;
                            odd = spin ? ^(beta_occ & span(0, int'(ii)))
                                       : ^(alpha_occ & span(0, int'(ii)));
                            beat.sign = odd ? SIGN_NEG : SIGN_POS;
                        end
                    end
                end
                OP_SGL: begin
                    if (int'(ii) >= n || int'(aa) >= n) begin
                        beat.err = 1'b1;
                    end else begin
                        if (spin) begin
                            beta_occ[ii] = 1'b0;
                            beta_occ[aa] = 1'b1;
                        end else begin
                            alpha_occ[ii] = 1'b0;
                            alpha_occ[aa] = 1'b1;
                        end
                        odd       = gap_parity(int'(ii) + off, int'(aa) + off);
                        beat.sign = odd ? SIGN_NEG : SIGN_POS;
                    end
                end
                OP_DAA, OP_DAB, OP_DBB: begin
                    if (int'(ii) >= n || int'(jj) >= n || int'(aa) >= n || int'(bb) >= n) begin
                        beat.err = 1'b1;
                    end else begin
                        oi = (op == OP_DBB) ? n : 0;
                        oj = (op == OP_DAA) ? 0 : n;
                        pi = int'(ii) + oi;
                        pa = int'(aa) + oi;
                        pj = int'(jj) + oj;
                        pb = int'(bb) + oj;
                        put_bit(pi, 1'b0);
                        put_bit(pj, 1'b0);
                        put_bit(pb, 1'b1);
                        put_bit(pa, 1'b1);
                        hb      = (pi < pa) && (pj < pa) && (pi < pb) && (pj < pb);
                        ha      = !((pi < pa) || (pj < pa) || (pi < pb) || (pj < pb));
                        crossed = (pi < pj) != (pa < pb);
                        if (hb || ha)
                            odd = crossed ^ gap_parity(pi, pj) ^ gap_parity(pa, pb);
                        else if (crossed)
                            odd = 1'b1 ^ gap_parity(pi, pb) ^ gap_parity(pj, pa);
                        else
                            odd = gap_parity(pi, pa) ^ gap_parity(pj, pb);
                        beat.sign = odd ? SIGN_NEG : SIGN_POS;
                    end
                end
                OP_FLIP: begin
                    ta        = alpha_occ;
                    tb        = beta_occ;
                    alpha_occ = (ta & ~lowm) | (tb & lowm);
                    beta_occ  = (tb & ~lowm) | (ta & lowm);
                end
                OP_ZERO: begin
                    if (spin) beta_occ &= ~lowm;
                    else alpha_occ &= ~lowm;
                end
                default: ;
            endcase
            beat.alpha = alpha_occ;
            beat.beta  = beta_occ;
            expected_beats.insert(expected_beats.size(), beat);
            beats_in++;
        endfunction

        function void check_beat(logic signed [W_SIGN-1:0] sign, t_word aw, t_word bw,
                                 logic err);
            t_phase_beat want;
            beats_out++;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: sign %0d alpha %h beta %h error %b",
                       sign, aw, bw, err);
                mismatches++;
                return;
            end
            want = expected_beats.pop_front();
            if (sign !== want.sign) begin
                $error("sign: expected %0d, got %0d", $signed(want.sign), sign);
                mismatches++;
            end
            if (aw !== want.alpha) begin
                $error("alpha_word: expected %h, got %h", want.alpha, aw);
                mismatches++;
            end
            if (bw !== want.beta) begin
                $error("beta_word: expected %h, got %h", want.beta, bw);
                mismatches++;
            end
            if (err !== want.err) begin
                $error("error: expected %b, got %b", want.err, err);
                mismatches++;
            end
        endfunction

    endclass

endpackage

FILE: bench/tb_determinant_excitation_sign_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_determinant_excitation_sign_unit - self-checking bench for the phase unit
// Directed operator beats over the corner cases, then random phases at several
// orbital counts (0, 1, small, 64 and saturated 127) with idle/stall patterns
// on both channels; every result beat is checked against a bench-side model.
// ----------------------------------------------------------------------------
module tb_determinant_excitation_sign_unit;

    import desu_pkg::*;
    import desu_tb_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          N_PHASES     = 9;
    localparam t_word       ALL_ONES     = '1;
    localparam t_word       CHECKER      = 64'hAAAA_AAAA_AAAA_AAAA;
    // spare operator codes, the unit must treat them as no-ops
    localparam logic [W_OP-1:0] OP_SPARE_LO = OP_ZERO + 4'd1;
    localparam logic [W_OP-1:0] OP_SPARE_HI = '1;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [W_CNT-1:0]         i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [W_OP-1:0]          i_op;
    logic                     i_spin;
    logic [W_IDX-1:0]         i_idx_i;
    logic [W_IDX-1:0]         i_idx_j;
    logic [W_IDX-1:0]         i_idx_a;
    logic [W_IDX-1:0]         i_idx_b;
    t_word                    i_load_alpha;
    t_word                    i_load_beta;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [W_SIGN-1:0] o_sign;
    t_word                    o_alpha_word;
    t_word                    o_beta_word;
    logic                     o_error;

    t_excitation_phase_board board;

    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // orbital count per random phase; the idle pattern cycles with the phase
    logic [W_CNT-1:0] phase_counts [N_PHASES] = '{7'd64, 7'd1, 7'd64, 7'd7, 7'd0,
                                                   7'd127, 7'd33, 7'd20, 7'd64};

    determinant_excitation_sign_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_spin       (i_spin),
        .i_idx_i      (i_idx_i),
        .i_idx_j      (i_idx_j),
        .i_idx_a      (i_idx_a),
        .i_idx_b      (i_idx_b),
        .i_load_alpha (i_load_alpha),
        .i_load_beta  (i_load_beta),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sign       (o_sign),
        .o_alpha_word (o_alpha_word),
        .o_beta_word  (o_beta_word),
        .o_error      (o_error)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("determinant_excitation_sign_unit verification failed");
            $finish;
        end
    end

    // result side: stall decided at the falling edge, beat taken at the rising edge
    always @(negedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_beat(o_sign, o_alpha_word, o_beta_word, o_error);
    end

    // mostly in-range orbitals, now and then any 6-bit value (error path)
    function automatic logic [W_IDX-1:0] pick_orbital();
        int n;
        n = board.orbitals_in_use();
        if (n == 0 || $urandom_range(0, 11) == 0)
            return W_IDX'($urandom);
        return W_IDX'($urandom_range(0, n - 1));
    endfunction

    // occupation words of varied density
    function automatic t_word random_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one operator beat: optional sender gaps, then hold until accepted
    task automatic send_op(input logic [W_OP-1:0] op, input logic spin,
                           input logic [W_IDX-1:0] ii, input logic [W_IDX-1:0] jj,
                           input logic [W_IDX-1:0] aa, input logic [W_IDX-1:0] bb,
                           input t_word la, input t_word lb);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_spin       <= spin;
        i_idx_i      <= ii;
        i_idx_j      <= jj;
        i_idx_a      <= aa;
        i_idx_b      <= bb;
        i_load_alpha <= la;
        i_load_beta  <= lb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.apply_operator(op, spin, ii, jj, aa, bb, la, lb);
    endtask

    // drop valid, wait for every result, then let the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write only once the unit is idle
    task automatic write_orbital_count(input logic [W_CNT-1:0] c);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        board.set_count(c);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [W_OP-1:0] op;
        int unsigned     roll;
        int unsigned     n_items;

        board          = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_op           = OP_LOAD;
        i_spin         = 1'b0;
        i_idx_i        = '0;
        i_idx_j        = '0;
        i_idx_a        = '0;
        i_idx_b        = '0;
        i_load_alpha   = '0;
        i_load_beta    = '0;
        i_out_stall    = 1'b0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed corners at the reset count of 64 ----
        send_op(OP_LOAD, 1'b0, 0, 0, 0, 0, ALL_ONES, CHECKER);
        send_op(OP_ANN,  1'b0, 63, 0, 0, 0, '0, '0);        // top orbital
        send_op(OP_ANN,  1'b0, 0, 0, 0, 0, '0, '0);         // bottom orbital
        send_op(OP_ANN,  1'b0, 0, 0, 0, 0, '0, '0);         // already empty: sign 0
        send_op(OP_CRE,  1'b0, 0, 0, 0, 0, '0, '0);
        send_op(OP_CRE,  1'b0, 5, 0, 0, 0, '0, '0);         // already occupied: sign 0
        send_op(OP_CRE,  1'b1, 0, 0, 0, 0, '0, '0);
        send_op(OP_SGL,  1'b0, 10, 0, 10, 0, '0, '0);       // hole equals particle
        send_op(OP_SGL,  1'b1, 1, 0, 63, 0, '0, '0);
        send_op(OP_SGL,  1'b0, 62, 0, 3, 0, '0, '0);        // hole above particle
        send_op(OP_DAA,  1'b0, 1, 2, 40, 41, '0, '0);       // holes below particles
        send_op(OP_DAA,  1'b0, 50, 40, 3, 4, '0, '0);       // holes above, crossed order
        send_op(OP_DAB,  1'b0, 5, 7, 60, 2, '0, '0);        // interleaved
        send_op(OP_DBB,  1'b1, 3, 30, 20, 10, '0, '0);      // crossed, interleaved
        send_op(OP_DAB,  1'b0, 63, 63, 63, 63, '0, '0);     // all indices at the top
        send_op(OP_FLIP, 1'b0, 0, 0, 0, 0, '0, '0);
        send_op(OP_ZERO, 1'b0, 0, 0, 0, 0, '0, '0);
        send_op(OP_ZERO, 1'b1, 0, 0, 0, 0, '0, '0);
        send_op(OP_SPARE_LO, 1'b1, 63, 63, 63, 63, ALL_ONES, ALL_ONES);
        send_op(OP_SPARE_HI, 1'b0, 0, 0, 0, 0, '0, '0);
        send_op(OP_LOAD, 1'b0, 0, 0, 0, 0, ALL_ONES, CHECKER);

        // shrink the count over a full determinant: high bits must stay put
        write_orbital_count(7'd5);
        send_op(OP_FLIP, 1'b0, 0, 0, 0, 0, '0, '0);
        send_op(OP_ANN,  1'b0, 5, 0, 0, 0, '0, '0);         // index out of range
        send_op(OP_DAB,  1'b1, 0, 0, 4, 63, '0, '0);        // one index out of range
        send_op(OP_ZERO, 1'b1, 0, 0, 0, 0, '0, '0);
        send_op(OP_LOAD, 1'b0, 0, 0, 0, 0, ALL_ONES, ALL_ONES);  // masked load
        send_op(OP_SGL,  1'b0, 0, 0, 4, 0, '0, '0);

        // ---- random phases: count setting and idle pattern per phase ----
        for (int p = 0; p < N_PHASES; p++) begin
            write_orbital_count(phase_counts[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            // a zero count sends every indexed operator down the error path, keep it short
            n_items = (phase_counts[p] == 0) ? 40 : 176;
            for (int k = 0; k < n_items; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 9)       op = OP_LOAD;
                else if (roll < 21) op = OP_CRE;
                else if (roll < 33) op = OP_ANN;
                else if (roll < 47) op = OP_SGL;
                else if (roll < 57) op = OP_DAA;
                else if (roll < 67) op = OP_DAB;
                else if (roll < 77) op = OP_DBB;
                else if (roll < 84) op = OP_FLIP;
                else if (roll < 90) op = OP_ZERO;
                else if (roll < 93) op = W_OP'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                else                op = OP_DAB;
                send_op(op, 1'($urandom), pick_orbital(), pick_orbital(),
                        pick_orbital(), pick_orbital(), random_word(), random_word());
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();

        $display("%0d operator beats sent, %0d result beats checked, %0d field mismatches",
                 board.beats_in, board.beats_out, board.mismatches);
        $display("covered orbital counts 0, 1, 5, 7, 20, 33, 64 and saturated 127 under idle and stall");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("determinant_excitation_sign_unit verification clean");
        end else begin
            $display("determinant_excitation_sign_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/desu_pkg.sv
rtl/determinant_excitation_sign_unit.sv
rtl/desu_checker.sv
bench/desu_tb_pkg.sv
bench/tb_determinant_excitation_sign_unit.sv
